// File: rtl/slkt_pkg.sv
// Shared types, constants and lookup functions for the source lexer.
// Used by slkt_core, slkt_token_fifo and source_lexer_keyword_tokens.
`timescale 1ns / 1ps
`default_nettype none

package slkt_pkg;

    localparam int MAX_KEYWORD_BYTES = 6;
    localparam int POSITION_BITS     = 24;
    localparam int KW_BITS           = 8 * MAX_KEYWORD_BYTES;
    localparam int RUN_BITS          = 16;
    localparam int OFF_BITS          = 24;
    localparam int KIND_BITS         = 6;
    localparam int FIFO_DEPTH        = 4;
    localparam int FIFO_PTR_BITS     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS     = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'd0,
        MODE_COMMENT = 4'd1,
        MODE_NUMBER  = 4'd2,
        MODE_IDENT   = 4'd3,
        MODE_EQ      = 4'd4,
        MODE_EXCL    = 4'd5,
        MODE_LT      = 4'd6,
        MODE_GT      = 4'd7
    } t_mode;

    typedef logic [KIND_BITS-1:0] t_kind;

    localparam t_kind K_LET      = 6'd0;
    localparam t_kind K_MUT      = 6'd1;
    localparam t_kind K_FN       = 6'd2;
    localparam t_kind K_RETURN   = 6'd3;
    localparam t_kind K_BOOL_LIT = 6'd4;
    localparam t_kind K_I8       = 6'd5;
    localparam t_kind K_I16      = 6'd6;
    localparam t_kind K_I32      = 6'd7;
    localparam t_kind K_I64      = 6'd8;
    localparam t_kind K_U8       = 6'd9;
    localparam t_kind K_U16      = 6'd10;
    localparam t_kind K_U32      = 6'd11;
    localparam t_kind K_U64      = 6'd12;
    localparam t_kind K_ISZ      = 6'd13;
    localparam t_kind K_USZ      = 6'd14;
    localparam t_kind K_BOOL     = 6'd15;
    localparam t_kind K_IF       = 6'd16;
    localparam t_kind K_ELIF     = 6'd17;
    localparam t_kind K_ELSE     = 6'd18;
    localparam t_kind K_WHILE    = 6'd19;
    localparam t_kind K_IDENT    = 6'd20;
    localparam t_kind K_LPAREN   = 6'd21;
    localparam t_kind K_RPAREN   = 6'd22;
    localparam t_kind K_LBRACE   = 6'd23;
    localparam t_kind K_RBRACE   = 6'd24;
    localparam t_kind K_LBRACK   = 6'd25;
    localparam t_kind K_RBRACK   = 6'd26;
    localparam t_kind K_COLON    = 6'd27;
    localparam t_kind K_SEMI     = 6'd28;
    localparam t_kind K_COMMA    = 6'd29;
    localparam t_kind K_PLUS     = 6'd30;
    localparam t_kind K_MINUS    = 6'd31;
    localparam t_kind K_STAR     = 6'd32;
    localparam t_kind K_SLASH    = 6'd33;
    localparam t_kind K_PERCENT  = 6'd34;
    localparam t_kind K_AT       = 6'd35;
    localparam t_kind K_EQUAL    = 6'd36;
    localparam t_kind K_EQEQ     = 6'd37;
    localparam t_kind K_ARROW    = 6'd38;
    localparam t_kind K_EXCL     = 6'd39;
    localparam t_kind K_EXCLEQ   = 6'd40;
    localparam t_kind K_LT       = 6'd41;
    localparam t_kind K_LTEQ     = 6'd42;
    localparam t_kind K_GT       = 6'd43;
    localparam t_kind K_GTEQ     = 6'd44;
    localparam t_kind K_INT      = 6'd45;
    localparam t_kind K_UNKNOWN  = 6'd46;
    localparam t_kind K_EOF      = 6'd47;

    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_HASH = "#";
    localparam logic [7:0] CH_US   = "_";
    localparam logic [7:0] CH_EQ   = "=";
    localparam logic [7:0] CH_EXCL = "!";
    localparam logic [7:0] CH_LT   = "<";
    localparam logic [7:0] CH_GT   = ">";

    typedef struct packed {
        t_kind                kind;
        logic [OFF_BITS-1:0]  offset;
        logic [RUN_BITS-1:0]  length;
        logic                 last;
    } t_token;

    // Tokens produced by one accepted byte, tok0 first.
    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_step;

    typedef struct packed {
        logic                     can_take;
        logic [FIFO_CNT_BITS-1:0] count;
    } t_fifo_status;

    typedef struct packed {
        logic  hit;
        t_kind kind;
    } t_kind_hit;

    function automatic logic is_num_char(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {["A":"Z"], ["a":"z"]}) || (c == CH_US);
    endfunction

    function automatic t_kind_hit punct_kind(input logic [7:0] c);
        t_kind_hit r;
        r.hit  = 1'b1;
        r.kind = K_UNKNOWN;
        case (c)
            "(": r.kind = K_LPAREN;
            ")": r.kind = K_RPAREN;
            "{": r.kind = K_LBRACE;
            "}": r.kind = K_RBRACE;
            "[": r.kind = K_LBRACK;
            "]": r.kind = K_RBRACK;
            ":": r.kind = K_COLON;
            ";": r.kind = K_SEMI;
            ",": r.kind = K_COMMA;
            "+": r.kind = K_PLUS;
            "-": r.kind = K_MINUS;
            "*": r.kind = K_STAR;
            "/": r.kind = K_SLASH;
            "%": r.kind = K_PERCENT;
            "@": r.kind = K_AT;
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

    // The prefix holds the first bytes of the run, right aligned, first byte highest.
    function automatic t_kind ident_kind(input logic [KW_BITS-1:0]  prefix,
                                         input logic [RUN_BITS-1:0] run);
        t_kind k;
        k = K_IDENT;
        if (run <= RUN_BITS'(MAX_KEYWORD_BYTES)) begin
            case (prefix)
                KW_BITS'("let"):    k = K_LET;
                KW_BITS'("mut"):    k = K_MUT;
                KW_BITS'("fn"):     k = K_FN;
                KW_BITS'("return"): k = K_RETURN;
                KW_BITS'("true"):   k = K_BOOL_LIT;
                KW_BITS'("false"):  k = K_BOOL_LIT;
                KW_BITS'("i8"):     k = K_I8;
                KW_BITS'("i16"):    k = K_I16;
                KW_BITS'("i32"):    k = K_I32;
                KW_BITS'("i64"):    k = K_I64;
                KW_BITS'("u8"):     k = K_U8;
                KW_BITS'("u16"):    k = K_U16;
                KW_BITS'("u32"):    k = K_U32;
                KW_BITS'("u64"):    k = K_U64;
                KW_BITS'("isz"):    k = K_ISZ;
                KW_BITS'("usz"):    k = K_USZ;
                KW_BITS'("bool"):   k = K_BOOL;
                KW_BITS'("if"):     k = K_IF;
                KW_BITS'("elif"):   k = K_ELIF;
                KW_BITS'("else"):   k = K_ELSE;
                KW_BITS'("while"):  k = K_WHILE;
                default:            k = K_IDENT;
            endcase
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// File: rtl/slkt_core.sv
// Lexer state registers and the per-byte next-state and token logic.
// Depends on slkt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slkt_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic [7:0]     i_ch,
    input  wire logic           i_eoi,
    output slkt_pkg::t_step     o_step
);

    slkt_pkg::t_mode                         r_mode, n_mode;
    logic [slkt_pkg::POSITION_BITS-1:0]      r_pos, n_pos;
    logic [slkt_pkg::POSITION_BITS-1:0]      r_tok_start, n_tok_start;
    logic [slkt_pkg::RUN_BITS-1:0]           r_run, n_run;
    logic [slkt_pkg::KW_BITS-1:0]            r_prefix, n_prefix;

    logic                 flush_v, fresh_v, use_flush, use_fresh;
    slkt_pkg::t_token     flush_tok, fresh_tok, pair_tok, first_tok;
    slkt_pkg::t_mode      fresh_mode;
    slkt_pkg::t_kind_hit  punct;
    logic [slkt_pkg::RUN_BITS-1:0] run_inc;

    // Token of the current mode, as if the run ended before this byte.
    always_comb begin
        flush_v          = 1'b1;
        flush_tok.offset = slkt_pkg::OFF_BITS'(r_tok_start);
        flush_tok.length = slkt_pkg::RUN_BITS'(1);
        flush_tok.last   = 1'b0;
        flush_tok.kind   = slkt_pkg::K_UNKNOWN;
        case (r_mode)
            slkt_pkg::MODE_NUMBER: begin
                flush_tok.kind   = slkt_pkg::K_INT;
                flush_tok.length = r_run;
            end
            slkt_pkg::MODE_IDENT: begin
                flush_tok.kind   = slkt_pkg::ident_kind(r_prefix, r_run);
                flush_tok.length = r_run;
            end
            slkt_pkg::MODE_EQ:   flush_tok.kind = slkt_pkg::K_EQUAL;
            slkt_pkg::MODE_EXCL: flush_tok.kind = slkt_pkg::K_EXCL;
            slkt_pkg::MODE_LT:   flush_tok.kind = slkt_pkg::K_LT;
            slkt_pkg::MODE_GT:   flush_tok.kind = slkt_pkg::K_GT;
            default:             flush_v = 1'b0;
        endcase
    end

    // Lexing of this byte from the idle mode.
    always_comb begin
        punct            = slkt_pkg::punct_kind(i_ch);
        fresh_v          = 1'b0;
        fresh_mode       = slkt_pkg::MODE_IDLE;
        fresh_tok.kind   = slkt_pkg::K_UNKNOWN;
        fresh_tok.offset = slkt_pkg::OFF_BITS'(r_pos);
        fresh_tok.length = slkt_pkg::RUN_BITS'(1);
        fresh_tok.last   = 1'b0;
        if (i_ch == slkt_pkg::CH_SP || i_ch == slkt_pkg::CH_NL || i_ch == slkt_pkg::CH_TAB) begin
            fresh_mode = slkt_pkg::MODE_IDLE;
        end else if (i_ch == slkt_pkg::CH_HASH) begin
            fresh_mode = slkt_pkg::MODE_COMMENT;
        end else if (punct.hit) begin
            fresh_v        = 1'b1;
            fresh_tok.kind = punct.kind;
        end else if (i_ch == slkt_pkg::CH_EQ) begin
            fresh_mode = slkt_pkg::MODE_EQ;
        end else if (i_ch == slkt_pkg::CH_EXCL) begin
            fresh_mode = slkt_pkg::MODE_EXCL;
        end else if (i_ch == slkt_pkg::CH_LT) begin
            fresh_mode = slkt_pkg::MODE_LT;
        end else if (i_ch == slkt_pkg::CH_GT) begin
            fresh_mode = slkt_pkg::MODE_GT;
        end else if (slkt_pkg::is_num_char(i_ch)) begin
            fresh_mode = slkt_pkg::MODE_NUMBER;
        end else if (slkt_pkg::is_alpha(i_ch)) begin
            fresh_mode = slkt_pkg::MODE_IDENT;
        end else begin
            fresh_v = 1'b1;
        end
    end

    assign run_inc = (r_run == {slkt_pkg::RUN_BITS{1'b1}}) ? r_run : r_run + 1'b1;

    always_comb begin
        n_mode          = r_mode;
        n_pos           = r_pos + 1'b1;
        n_tok_start     = r_tok_start;
        n_run           = r_run;
        n_prefix        = r_prefix;
        use_flush       = 1'b0;
        use_fresh       = 1'b0;
        pair_tok.kind   = slkt_pkg::K_EOF;
        pair_tok.offset = slkt_pkg::OFF_BITS'(r_pos);
        pair_tok.length = '0;
        pair_tok.last   = 1'b0;

        if (i_eoi) begin
            // End of file: flush, then the end-of-file token, then back to reset state.
            use_flush   = 1'b1;
            n_mode      = slkt_pkg::MODE_IDLE;
            n_pos       = '0;
            n_tok_start = '0;
            n_run       = '0;
            n_prefix    = '0;
        end else begin
            case (r_mode)
                slkt_pkg::MODE_COMMENT: begin
                    if (i_ch == slkt_pkg::CH_NL) begin
                        n_mode = slkt_pkg::MODE_IDLE;
                    end
                end
                slkt_pkg::MODE_NUMBER: begin
                    if (slkt_pkg::is_num_char(i_ch)) begin
                        n_run = run_inc;
                    end else begin
                        use_flush = 1'b1;
                        use_fresh = 1'b1;
                    end
                end
                slkt_pkg::MODE_IDENT: begin
                    if (slkt_pkg::is_alpha(i_ch) || slkt_pkg::is_num_char(i_ch)) begin
                        if (r_run < slkt_pkg::RUN_BITS'(slkt_pkg::MAX_KEYWORD_BYTES)) begin
                            n_prefix = {r_prefix[slkt_pkg::KW_BITS-9:0], i_ch};
                        end
                        n_run = run_inc;
                    end else begin
                        use_flush = 1'b1;
                        use_fresh = 1'b1;
                    end
                end
                slkt_pkg::MODE_EQ, slkt_pkg::MODE_EXCL,
                slkt_pkg::MODE_LT, slkt_pkg::MODE_GT: begin
                    if (i_ch == slkt_pkg::CH_EQ ||
                        (i_ch == slkt_pkg::CH_GT && r_mode == slkt_pkg::MODE_EQ)) begin
                        // Two-byte operator completes here.
                        n_mode          = slkt_pkg::MODE_IDLE;
                        pair_tok.offset = slkt_pkg::OFF_BITS'(r_tok_start);
                        pair_tok.length = slkt_pkg::RUN_BITS'(2);
                        case (r_mode)
                            slkt_pkg::MODE_EQ:   pair_tok.kind = (i_ch == slkt_pkg::CH_EQ) ?
                                                     slkt_pkg::K_EQEQ : slkt_pkg::K_ARROW;
                            slkt_pkg::MODE_EXCL: pair_tok.kind = slkt_pkg::K_EXCLEQ;
                            slkt_pkg::MODE_LT:   pair_tok.kind = slkt_pkg::K_LTEQ;
                            default:             pair_tok.kind = slkt_pkg::K_GTEQ;
                        endcase
                    end else begin
                        use_flush = 1'b1;
                        use_fresh = 1'b1;
                    end
                end
                default: begin
                    use_fresh = 1'b1;
                end
            endcase

            // Entering from idle always reloads the run registers; they are only
            // read in the modes that this load starts.
            if (use_fresh) begin
                n_mode      = fresh_mode;
                n_tok_start = r_pos;
                n_run       = slkt_pkg::RUN_BITS'(1);
                n_prefix    = slkt_pkg::KW_BITS'(i_ch);
            end
        end
    end

    // Order the tokens: flushed token first, then the token of this byte.
    logic a_v, b_v;
    slkt_pkg::t_token b_tok;

    always_comb begin
        a_v   = use_flush && flush_v;
        b_v   = i_eoi ? 1'b1 : (use_fresh ? fresh_v : (pair_tok.length != '0));
        b_tok = (i_eoi || !use_fresh) ? pair_tok : fresh_tok;

        first_tok      = a_v ? flush_tok : b_tok;
        first_tok.last = !(a_v && b_v);

        o_step.tok0      = first_tok;
        o_step.tok1      = b_tok;
        o_step.tok1.last = 1'b1;
        o_step.count     = i_accept ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= slkt_pkg::MODE_IDLE;
            r_pos       <= '0;
            r_tok_start <= '0;
            r_run       <= '0;
            r_prefix    <= '0;
        end else if (i_accept) begin
            r_mode      <= n_mode;
            r_pos       <= n_pos;
            r_tok_start <= n_tok_start;
            r_run       <= n_run;
            r_prefix    <= n_prefix;
        end
    end

endmodule

`default_nettype wire

// File: rtl/slkt_token_fifo.sv
// Token queue: takes up to two tokens per cycle, gives one per cycle while popped.
// Depends on slkt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slkt_token_fifo (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire slkt_pkg::t_step     i_step,
    input  wire logic                i_pop,
    output slkt_pkg::t_token         o_head,
    output slkt_pkg::t_fifo_status   o_status
);

    slkt_pkg::t_token                         mem [slkt_pkg::FIFO_DEPTH];
    logic [slkt_pkg::FIFO_PTR_BITS-1:0]       r_wr, n_wr, r_rd, n_rd, wr_next;
    logic [slkt_pkg::FIFO_CNT_BITS-1:0]       r_count, n_count;

    assign wr_next = r_wr + 1'b1;

    always_comb begin
        n_wr    = r_wr + slkt_pkg::FIFO_PTR_BITS'(i_step.count);
        n_rd    = i_pop ? r_rd + 1'b1 : r_rd;
        n_count = r_count + slkt_pkg::FIFO_CNT_BITS'(i_step.count)
                  - slkt_pkg::FIFO_CNT_BITS'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_step.count != 2'd0) begin
            mem[r_wr] <= i_step.tok0;
        end
        if (i_step.count == 2'd2) begin
            mem[wr_next] <= i_step.tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    assign o_head            = mem[r_rd];
    assign o_status.count    = r_count;
    // Room for the two tokens that one byte can cause.
    assign o_status.can_take = r_count <= slkt_pkg::FIFO_CNT_BITS'(slkt_pkg::FIFO_DEPTH - 2);

endmodule

`default_nettype wire

// File: rtl/source_lexer_keyword_tokens.sv
// Streaming lexer top level: byte input channel, token output channel.
// Depends on slkt_pkg, slkt_core and slkt_token_fifo.
//
// Usage: source bytes arrive one word at a time on the s_axis channel; s_axis_tdata
// carries the byte and s_axis_tlast marks end of input (the byte is then ignored).
// Tokens leave on the m_axis channel, one word per token; m_axis_tlast is set on the
// last token that a given input word caused. One input word causes zero, one or
// two tokens (a run ended by the byte, then the byte's own token; or the pending
// token and end-of-file at end of input).
// A token is written to the queue when the word that caused it is accepted, and is
// offered on m_axis once the tokens ahead of it have left. One input word is taken
// per cycle while the queue has room; the lexer state update is a single short step
// per byte, and a four-entry token queue decouples the two sides. s_axis_tready is
// high while the queue has room for two tokens, so when the receiver stalls the
// queue fills and input is held off; no token is ever dropped.
// After end of input the lexer returns to its reset state and the next byte has
// offset zero. Reset (synchronous, active low) empties the queue and clears the
// lexer state; the block is ready as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module source_lexer_keyword_tokens (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  wire logic        s_axis_tlast,   // end_of_input
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [5:0] token_kind, [29:6] start_offset,
                                             // [45:30] token_length, [47:46] zero
    output logic             m_axis_tlast    // last_of_run
);

    logic                    in_accept;
    logic                    out_pop;
    slkt_pkg::t_step         step;
    slkt_pkg::t_token        head;
    slkt_pkg::t_fifo_status  fifo_status;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    // Lexer state and per-byte decision logic.
    slkt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_ch     (s_axis_tdata),
        .i_eoi    (s_axis_tlast),
        .o_step   (step)
    );

    // Output queue; its head drives the master side directly.
    slkt_token_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_pop    (out_pop),
        .o_head   (head),
        .o_status (fifo_status)
    );

    assign s_axis_tready = fifo_status.can_take;
    assign m_axis_tvalid = (fifo_status.count != '0);
    assign out_pop       = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = {2'b00, head.length, head.offset, head.kind};
    assign m_axis_tlast  = head.last;

    // The queue never holds more tokens than it has entries.
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_status.count <= slkt_pkg::FIFO_CNT_BITS'(slkt_pkg::FIFO_DEPTH))
        else $error("token queue overflow");

    // End of input always leaves at least the end-of-file token queued.
    a_eof_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && s_axis_tlast |=> m_axis_tvalid)
        else $error("no token after end of input");

    // The end-of-file token is always the last of its run and has zero length.
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && head.kind == slkt_pkg::K_EOF |-> m_axis_tlast && head.length == '0)
        else $error("end-of-file token malformed");

endmodule

`default_nettype wire
